// ===== src/sbe_market_data_decoder_macros.svh =====
// Assertion helpers for the decoder.
`ifndef SBE_MARKET_DATA_DECODER_MACROS_SVH
`define SBE_MARKET_DATA_DECODER_MACROS_SVH
// Assert that the antecedent implies the consequent in the same cycle.
`define SBE_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Assert that the antecedent implies the consequent in the next cycle.
`define SBE_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== src/sbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sbe_pkg;
  localparam int unsigned FRAME_BYTES = 65536;
  localparam int FPOS_W = $clog2(FRAME_BYTES + 1);
  localparam logic [15:0] QUOTE_RESET = 16'd10001;
  localparam logic [15:0] TRADE_RESET = 16'd10000;
  localparam logic [15:0] QUOTE_MIN = 16'd50;
  localparam logic [15:0] TRADE_MIN = 16'd18;
  localparam logic [15:0] ENTRY_MIN = 16'd25;
  localparam logic [0:0] REG_QUOTE = 1'b0;
  localparam logic [0:0] REG_TRADE = 1'b1;

  typedef enum logic [2:0] {
    PH_HDR, PH_BLOCK, PH_GRP, PH_ENTRY, PH_VLEN, PH_VSKIP, PH_DROP
  } phase_t;

  typedef enum logic [1:0] {
    CL_QUOTE, CL_TRADE, CL_UNKNOWN
  } class_t;

  typedef enum logic [1:0] {
    KIND_QUOTE = 2'd0, KIND_TRADE = 2'd1, KIND_UNKNOWN = 2'd2, KIND_BAD = 2'd3
  } kind_t;

  // Result payload, the last field in the lowest bits.
  typedef struct packed {
    logic [7:0]  buyer_is_maker;
    logic signed [7:0]  qty_exponent;
    logic signed [7:0]  price_exponent;
    logic signed [63:0] ask_qty_mantissa;
    logic signed [63:0] ask_price_mantissa;
    logic signed [63:0] qty_mantissa;
    logic signed [63:0] price_mantissa;
    logic signed [63:0] sequence_id;
    logic signed [63:0] event_time;
    logic [15:0] template_number;
    logic [1:0]  record_kind;
  } result_t;
endpackage
`default_nettype wire

// ===== src/sbe_market_data_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Beat contents
// s_axis   | in        | tdata[7:0] data_byte, tlast frame_end
// m_axis   | out       | tdata: record fields packed from record_kind up (426 bits, 432 wide)
// cfg      | in        | cfg_index selects the register, cfg_data is written
//
// One byte beat is taken every cycle unless the input stalls. Each beat is
// parsed in the cycle it is accepted and any record lands in the output
// register on that edge, so results appear in the cycle after their byte. The
// input stalls only while a result is held in the output register and not yet taken.
// Reset is synchronous and returns the parser to the header phase.
`include "sbe_market_data_decoder_macros.svh"
module sbe_market_data_decoder (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tlast,   // frame_end
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // record_kind, template_number, event_time, sequence_id, price_mantissa,
  // qty_mantissa, ask_price_mantissa, ask_qty_mantissa, price_exponent,
  // qty_exponent, buyer_is_maker (lowest first); bits 431:426 are zero
  output logic [431:0]      m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  logic [15:0] quote_template, trade_template;
  sbe_pkg::phase_t phase, phase_next;
  sbe_pkg::class_t msg_class, msg_class_next;
  logic [15:0] byte_count, byte_count_next;
  logic [63:0] header_shift, header_shift_next;
  logic [15:0] block_len, block_len_next;
  logic [15:0] template_reg, template_reg_next;
  logic [63:0] time_reg, time_reg_next, seq_reg, seq_reg_next;
  logic [15:0] exp_regs, exp_regs_next;
  logic [63:0] mant [4];
  logic [63:0] mant_next [4];
  logic [15:0] entry_len, entry_len_next;
  logic [31:0] entries_left, entries_left_next;
  logic [15:0] skip_left, skip_left_next;
  logic [sbe_pkg::FPOS_W-1:0] frame_pos, frame_pos_next;
  sbe_pkg::result_t res, res_next;
  logic emit_v;
  logic take;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign m_axis_tdata = {6'd0, res};

  // Byte lane within a 64-bit field.
  function automatic logic [63:0] set_byte(logic [63:0] v, logic [2:0] i,
                                           logic [7:0] b);
    logic [63:0] r;
    r = v;
    r[{i, 3'b000} +: 8] = b;
    return r;
  endfunction

  // Records carry template 0 when raised from the header phase.
  function automatic sbe_pkg::result_t mk(sbe_pkg::kind_t k, sbe_pkg::phase_t ph,
      logic [15:0] tpl, logic [63:0] t, logic [63:0] s, logic [63:0] m0,
      logic [63:0] m1, logic [63:0] m2, logic [63:0] m3, logic [15:0] e);
    sbe_pkg::result_t r;
    r = '0;
    r.record_kind = k;
    r.template_number = (ph == sbe_pkg::PH_HDR) ? 16'd0 : tpl;
    if (k == sbe_pkg::KIND_QUOTE || k == sbe_pkg::KIND_TRADE) begin
      r.event_time = t;
      r.sequence_id = s;
      r.price_mantissa = m0;
      r.qty_mantissa = m1;
      r.ask_price_mantissa = (k == sbe_pkg::KIND_QUOTE) ? m2 : 64'd0;
      r.ask_qty_mantissa = (k == sbe_pkg::KIND_QUOTE) ? m3 : 64'd0;
      r.price_exponent = e[7:0];
      r.qty_exponent = e[15:8];
    end
    return r;
  endfunction

  always_comb begin
    logic [15:0] off;
    logic [63:0] hs;
    logic [15:0] tpl, bl, el;
    logic [31:0] cnt;
    logic [4:0] qo;
    logic clean;
    off = byte_count;
    hs = '0;
    tpl = '0;
    bl = '0;
    el = '0;
    cnt = '0;
    qo = '0;
    clean = 1'b0;
    phase_next = phase;
    msg_class_next = msg_class;
    byte_count_next = byte_count;
    header_shift_next = header_shift;
    block_len_next = block_len;
    template_reg_next = template_reg;
    time_reg_next = time_reg;
    seq_reg_next = seq_reg;
    exp_regs_next = exp_regs;
    for (int i = 0; i < 4; i++) mant_next[i] = mant[i];
    entry_len_next = entry_len;
    entries_left_next = entries_left;
    skip_left_next = skip_left;
    frame_pos_next = frame_pos;
    emit_v = 1'b0;
    res_next = res;
    if (frame_pos >= sbe_pkg::FPOS_W'(sbe_pkg::FRAME_BYTES)) begin
      if (phase != sbe_pkg::PH_DROP) begin
        res_next = mk(sbe_pkg::KIND_BAD, phase, template_reg, time_reg, seq_reg,
                      mant[0], mant[1], mant[2], mant[3], exp_regs);
        emit_v = 1'b1;
        phase_next = sbe_pkg::PH_DROP;
      end
    end else begin
      frame_pos_next = frame_pos + 1'b1;
      case (phase)
        sbe_pkg::PH_HDR: begin
          hs = set_byte(header_shift, off[2:0], s_axis_tdata);
          header_shift_next = hs;
          if (off < 16'd7) begin
            byte_count_next = off + 16'd1;
          end else begin
            bl = hs[15:0];
            tpl = hs[31:16];
            block_len_next = bl;
            template_reg_next = tpl;
            byte_count_next = '0;
            phase_next = sbe_pkg::PH_BLOCK;
            if (tpl == quote_template) msg_class_next = sbe_pkg::CL_QUOTE;
            else if (tpl == trade_template) msg_class_next = sbe_pkg::CL_TRADE;
            else msg_class_next = sbe_pkg::CL_UNKNOWN;
            if ((msg_class_next == sbe_pkg::CL_QUOTE && bl < sbe_pkg::QUOTE_MIN) ||
                (msg_class_next == sbe_pkg::CL_TRADE && bl < sbe_pkg::TRADE_MIN)) begin
              res_next = mk(sbe_pkg::KIND_BAD, sbe_pkg::PH_BLOCK, tpl, time_reg,
                            seq_reg, mant[0], mant[1], mant[2], mant[3], exp_regs);
              emit_v = 1'b1;
              phase_next = sbe_pkg::PH_DROP;
            end else begin
              if (bl == 16'd0) begin
                header_shift_next = '0;
                phase_next = (msg_class_next == sbe_pkg::CL_TRADE) ?
                             sbe_pkg::PH_GRP : sbe_pkg::PH_VLEN;
              end
              if (msg_class_next == sbe_pkg::CL_UNKNOWN) begin
                res_next = mk(sbe_pkg::KIND_UNKNOWN, phase_next, tpl, time_reg,
                              seq_reg, mant[0], mant[1], mant[2], mant[3], exp_regs);
                emit_v = 1'b1;
              end
            end
          end
        end
        sbe_pkg::PH_BLOCK: begin
          if (msg_class != sbe_pkg::CL_UNKNOWN) begin
            if (off < 16'd8) begin
              time_reg_next = set_byte(time_reg, off[2:0], s_axis_tdata);
            end else if (off < 16'd16) begin
              if (msg_class == sbe_pkg::CL_QUOTE)
                seq_reg_next = set_byte(seq_reg, off[2:0], s_axis_tdata);
            end else if (off == 16'd16) begin
              exp_regs_next[7:0] = s_axis_tdata;
            end else if (off == 16'd17) begin
              exp_regs_next[15:8] = s_axis_tdata;
            end else if (msg_class == sbe_pkg::CL_QUOTE && off < sbe_pkg::QUOTE_MIN) begin
              qo = 5'(off - 16'd18);
              mant_next[qo[4:3]] = set_byte(mant[qo[4:3]], qo[2:0], s_axis_tdata);
            end
          end
          if ({1'b0, off} + 17'd1 < {1'b0, block_len}) begin
            byte_count_next = off + 16'd1;
          end else begin
            byte_count_next = '0;
            header_shift_next = '0;
            phase_next = (msg_class == sbe_pkg::CL_TRADE) ?
                         sbe_pkg::PH_GRP : sbe_pkg::PH_VLEN;
            if (msg_class == sbe_pkg::CL_QUOTE) begin
              res_next = mk(sbe_pkg::KIND_QUOTE, phase_next, template_reg,
                            time_reg_next, seq_reg_next, mant_next[0], mant_next[1],
                            mant_next[2], mant_next[3], exp_regs_next);
              emit_v = 1'b1;
            end
          end
        end
        sbe_pkg::PH_GRP: begin
          hs = set_byte(header_shift, off[2:0], s_axis_tdata);
          header_shift_next = hs;
          if (off < 16'd5) begin
            byte_count_next = off + 16'd1;
          end else begin
            el = hs[15:0];
            cnt = hs[47:16];
            entry_len_next = el;
            entries_left_next = cnt;
            byte_count_next = '0;
            if (cnt == 32'd0) begin
              phase_next = sbe_pkg::PH_VLEN;
            end else if (el < sbe_pkg::ENTRY_MIN) begin
              res_next = mk(sbe_pkg::KIND_BAD, phase, template_reg, time_reg,
                            seq_reg, mant[0], mant[1], mant[2], mant[3], exp_regs);
              emit_v = 1'b1;
              phase_next = sbe_pkg::PH_DROP;
            end else begin
              phase_next = sbe_pkg::PH_ENTRY;
            end
          end
        end
        sbe_pkg::PH_ENTRY: begin
          if (off < 16'd8) seq_reg_next = set_byte(seq_reg, off[2:0], s_axis_tdata);
          else if (off < 16'd16) mant_next[0] = set_byte(mant[0], off[2:0], s_axis_tdata);
          else if (off < 16'd24) mant_next[1] = set_byte(mant[1], off[2:0], s_axis_tdata);
          else if (off == 16'd24) begin
            res_next = mk(sbe_pkg::KIND_TRADE, phase, template_reg, time_reg, seq_reg,
                          mant[0], mant[1], mant[2], mant[3], exp_regs);
            res_next.buyer_is_maker = s_axis_tdata;
            emit_v = 1'b1;
          end
          if ({1'b0, off} + 17'd1 < {1'b0, entry_len}) begin
            byte_count_next = off + 16'd1;
          end else begin
            byte_count_next = '0;
            entries_left_next = entries_left - 32'd1;
            if (entries_left_next == 32'd0) phase_next = sbe_pkg::PH_VLEN;
          end
        end
        sbe_pkg::PH_VLEN: begin
          skip_left_next = {8'd0, s_axis_tdata};
          byte_count_next = '0;
          header_shift_next = '0;
          phase_next = (s_axis_tdata == 8'd0) ? sbe_pkg::PH_HDR : sbe_pkg::PH_VSKIP;
        end
        sbe_pkg::PH_VSKIP: begin
          skip_left_next = skip_left - 16'd1;
          if (skip_left_next == 16'd0) begin
            phase_next = sbe_pkg::PH_HDR;
            byte_count_next = '0;
            header_shift_next = '0;
          end
        end
        default: ;
      endcase
    end
    if (s_axis_tlast) begin
      clean = (phase_next == sbe_pkg::PH_HDR && byte_count_next == 16'd0) ||
              phase_next == sbe_pkg::PH_VLEN || phase_next == sbe_pkg::PH_DROP;
      if (!emit_v && !clean) begin
        res_next = mk(sbe_pkg::KIND_BAD, phase_next, template_reg_next, time_reg_next,
                      seq_reg_next, mant_next[0], mant_next[1], mant_next[2],
                      mant_next[3], exp_regs_next);
        emit_v = 1'b1;
      end
      phase_next = sbe_pkg::PH_HDR;
      byte_count_next = '0;
      header_shift_next = '0;
      frame_pos_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_template <= sbe_pkg::QUOTE_RESET;
      trade_template <= sbe_pkg::TRADE_RESET;
      phase <= sbe_pkg::PH_HDR;
      msg_class <= sbe_pkg::CL_UNKNOWN;
      byte_count <= '0;
      header_shift <= '0;
      block_len <= '0;
      template_reg <= '0;
      time_reg <= '0;
      seq_reg <= '0;
      exp_regs <= '0;
      for (int i = 0; i < 4; i++) mant[i] <= '0;
      entry_len <= '0;
      entries_left <= '0;
      skip_left <= '0;
      frame_pos <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == sbe_pkg::REG_QUOTE) quote_template <= cfg_data;
        else trade_template <= cfg_data;
      end
      // A new record may replace the one taken on this same edge.
      if (take && emit_v) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (take) begin
        phase <= phase_next;
        msg_class <= msg_class_next;
        byte_count <= byte_count_next;
        header_shift <= header_shift_next;
        block_len <= block_len_next;
        template_reg <= template_reg_next;
        time_reg <= time_reg_next;
        seq_reg <= seq_reg_next;
        exp_regs <= exp_regs_next;
        for (int i = 0; i < 4; i++) mant[i] <= mant_next[i];
        entry_len <= entry_len_next;
        entries_left <= entries_left_next;
        skip_left <= skip_left_next;
        frame_pos <= frame_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit_v) res <= res_next;
  end

  `SBE_ASSERT_NEXT(a_last_to_hdr, take && s_axis_tlast, phase == sbe_pkg::PH_HDR && byte_count == 16'd0)
  `SBE_ASSERT_NEXT(a_hold_result, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(res))
  `SBE_ASSERT_IMP(a_frame_bound, 1'b1, frame_pos <= sbe_pkg::FPOS_W'(sbe_pkg::FRAME_BYTES))
endmodule
`default_nettype wire

// ===== tb/sbe_market_data_decoder_tb.sv =====
`timescale 1ns / 1ps
module sbe_market_data_decoder_tb;
  localparam int CYCLE_LIMIT = 200000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [431:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  sbe_market_data_decoder u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Idle percentages for the byte sender and the record receiver.
  int src_idle = 0;
  int snk_idle = 0;
  int fail_count = 0;
  int cycles = 0;

  // Records that the parser copy says are still owed by the block.
  sbe_pkg::result_t pending_records[$];
  // Bytes of the frame under construction.
  logic [7:0] frame_bytes[$];

  // Behavioral copy of the parser state and its two template registers.
  logic [15:0] quote_id, trade_id;
  sbe_pkg::phase_t ph;
  int unsigned cnt, fpos;
  logic [63:0] hdr, tm_r, seq_r;
  logic [15:0] blen, tmpl, exps, elen, skip;
  logic [63:0] mant[4];
  logic [31:0] eleft;
  sbe_pkg::class_t cls;

  task automatic parser_reset();
    quote_id = sbe_pkg::QUOTE_RESET;
    trade_id = sbe_pkg::TRADE_RESET;
    ph = sbe_pkg::PH_HDR;
    cnt = 0;
    fpos = 0;
    hdr = '0;
    tm_r = '0;
    seq_r = '0;
    blen = '0;
    tmpl = '0;
    exps = '0;
    elen = '0;
    skip = '0;
    eleft = '0;
    for (int i = 0; i < 4; i++) mant[i] = '0;
    cls = sbe_pkg::CL_UNKNOWN;
  endtask

  // A record reflects the current phase: in the header phase no template is known yet.
  function automatic sbe_pkg::result_t make_record(sbe_pkg::kind_t k);
    sbe_pkg::result_t r = '0;
    r.record_kind = k;
    r.template_number = (ph == sbe_pkg::PH_HDR) ? 16'd0 : tmpl;
    if (k == sbe_pkg::KIND_QUOTE || k == sbe_pkg::KIND_TRADE) begin
      r.event_time = tm_r;
      r.sequence_id = seq_r;
      r.price_mantissa = mant[0];
      r.qty_mantissa = mant[1];
      r.ask_price_mantissa = (k == sbe_pkg::KIND_QUOTE) ? mant[2] : 64'd0;
      r.ask_qty_mantissa = (k == sbe_pkg::KIND_QUOTE) ? mant[3] : 64'd0;
      r.price_exponent = exps[7:0];
      r.qty_exponent = exps[15:8];
    end
    return r;
  endfunction

  task automatic block_done();
    cnt = 0;
    hdr = '0;
    ph = (cls == sbe_pkg::CL_TRADE) ? sbe_pkg::PH_GRP : sbe_pkg::PH_VLEN;
  endtask

  task automatic parse_byte(input logic [7:0] b, output bit got,
                            output sbe_pkg::result_t rec);
    int unsigned off;
    off = cnt;
    got = 0;
    rec = '0;
    case (ph)
      sbe_pkg::PH_HDR: begin
        hdr[8*(off%8) +: 8] = b;
        if (off < 7) begin
          cnt = off + 1;
        end else begin
          blen = hdr[15:0];
          tmpl = hdr[31:16];
          cnt = 0;
          ph = sbe_pkg::PH_BLOCK;
          if (tmpl == quote_id) cls = sbe_pkg::CL_QUOTE;
          else if (tmpl == trade_id) cls = sbe_pkg::CL_TRADE;
          else cls = sbe_pkg::CL_UNKNOWN;
          if ((cls == sbe_pkg::CL_QUOTE && blen < sbe_pkg::QUOTE_MIN) ||
              (cls == sbe_pkg::CL_TRADE && blen < sbe_pkg::TRADE_MIN)) begin
            rec = make_record(sbe_pkg::KIND_BAD);
            ph = sbe_pkg::PH_DROP;
            got = 1;
          end else begin
            if (blen == 0) block_done();
            if (cls == sbe_pkg::CL_UNKNOWN) begin
              rec = make_record(sbe_pkg::KIND_UNKNOWN);
              got = 1;
            end
          end
        end
      end
      sbe_pkg::PH_BLOCK: begin
        if (cls != sbe_pkg::CL_UNKNOWN) begin
          if (off < 8) tm_r[8*off +: 8] = b;
          else if (off < 16) begin
            if (cls == sbe_pkg::CL_QUOTE) seq_r[8*(off%8) +: 8] = b;
          end
          else if (off == 16) exps[7:0] = b;
          else if (off == 17) exps[15:8] = b;
          else if (cls == sbe_pkg::CL_QUOTE && off < sbe_pkg::QUOTE_MIN)
            mant[((off-18)/8)%4][8*((off-18)%8) +: 8] = b;
        end
        if (off + 1 < blen) begin
          cnt = off + 1;
        end else begin
          block_done();
          if (cls == sbe_pkg::CL_QUOTE) begin
            rec = make_record(sbe_pkg::KIND_QUOTE);
            got = 1;
          end
        end
      end
      sbe_pkg::PH_GRP: begin
        hdr[8*(off%8) +: 8] = b;
        if (off < 5) begin
          cnt = off + 1;
        end else begin
          elen = hdr[15:0];
          eleft = hdr[47:16];
          cnt = 0;
          if (eleft == 0) ph = sbe_pkg::PH_VLEN;
          else if (elen < sbe_pkg::ENTRY_MIN) begin
            rec = make_record(sbe_pkg::KIND_BAD);
            ph = sbe_pkg::PH_DROP;
            got = 1;
          end else ph = sbe_pkg::PH_ENTRY;
        end
      end
      sbe_pkg::PH_ENTRY: begin
        if (off < 8) seq_r[8*off +: 8] = b;
        else if (off < 16) mant[0][8*(off%8) +: 8] = b;
        else if (off < 24) mant[1][8*(off%8) +: 8] = b;
        else if (off == 24) begin
          rec = make_record(sbe_pkg::KIND_TRADE);
          rec.buyer_is_maker = b;
          got = 1;
        end
        if (off + 1 < elen) begin
          cnt = off + 1;
        end else begin
          cnt = 0;
          eleft = eleft - 1;
          if (eleft == 0) ph = sbe_pkg::PH_VLEN;
        end
      end
      sbe_pkg::PH_VLEN: begin
        skip = b;
        cnt = 0;
        hdr = '0;
        ph = (b == 0) ? sbe_pkg::PH_HDR : sbe_pkg::PH_VSKIP;
      end
      sbe_pkg::PH_VSKIP: begin
        skip = skip - 1;
        if (skip == 0) begin
          ph = sbe_pkg::PH_HDR;
          cnt = 0;
          hdr = '0;
        end
      end
      default: ;
    endcase
  endtask

  // Frame-level wrapper: size limit and the end-of-frame truncation check.
  task automatic predict_beat(input logic [7:0] b, input logic last);
    bit got, clean;
    sbe_pkg::result_t rec;
    got = 0;
    rec = '0;
    if (fpos >= sbe_pkg::FRAME_BYTES) begin
      if (ph != sbe_pkg::PH_DROP) begin
        rec = make_record(sbe_pkg::KIND_BAD);
        ph = sbe_pkg::PH_DROP;
        got = 1;
      end
    end else begin
      fpos++;
      parse_byte(b, got, rec);
    end
    if (last) begin
      clean = (ph == sbe_pkg::PH_HDR && cnt == 0) || ph == sbe_pkg::PH_VLEN ||
              ph == sbe_pkg::PH_DROP;
      if (!got && !clean) begin
        rec = make_record(sbe_pkg::KIND_BAD);
        got = 1;
      end
      ph = sbe_pkg::PH_HDR;
      cnt = 0;
      hdr = '0;
      fpos = 0;
    end
    if (got) pending_records.push_back(rec);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] seen);
    if (want !== seen) begin
      if (fail_count < 10)
        $display("record mismatch on %s: expected %h, got %h", name, want, seen);
      fail_count++;
    end
  endtask

  // Monitor: beats are sampled at the edge, before the driver's updates land.
  always @(posedge clk) begin
    sbe_pkg::result_t want, seen;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = sbe_pkg::result_t'(m_axis_tdata[425:0]);
        if (pending_records.size() == 0) begin
          if (fail_count < 10) $display("unexpected record beat, kind %0d", seen.record_kind);
          fail_count++;
        end else begin
          want = pending_records.pop_front();
          check_field("record_kind", want.record_kind, seen.record_kind);
          check_field("template_number", want.template_number, seen.template_number);
          check_field("event_time", want.event_time, seen.event_time);
          check_field("sequence_id", want.sequence_id, seen.sequence_id);
          check_field("price_mantissa", want.price_mantissa, seen.price_mantissa);
          check_field("qty_mantissa", want.qty_mantissa, seen.qty_mantissa);
          check_field("ask_price_mantissa", want.ask_price_mantissa, seen.ask_price_mantissa);
          check_field("ask_qty_mantissa", want.ask_qty_mantissa, seen.ask_qty_mantissa);
          check_field("price_exponent", want.price_exponent, seen.price_exponent);
          check_field("qty_exponent", want.qty_exponent, seen.qty_exponent);
          check_field("buyer_is_maker", want.buyer_is_maker, seen.buyer_is_maker);
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_beat(s_axis_tdata, s_axis_tlast);
    end
  end

  // The receiver stalls at random according to snk_idle.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sbe_market_data_decoder_tb NOT OK");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  // Drain every owed record, then give the last byte time to settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == sbe_pkg::REG_QUOTE) quote_id = val;
    else trade_id = val;
    @(posedge clk);
  endtask

  task automatic put_le(input logic [63:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) frame_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic put_header(input logic [15:0] bl, input logic [15:0] id);
    put_le(bl, 2);
    put_le(id, 2);
    put_rand(4);
  endtask

  // A var string length byte and its bytes; vlen < 0 leaves it out.
  task automatic put_varstr(input int vlen);
    if (vlen >= 0) begin
      frame_bytes.push_back(8'(vlen));
      put_rand(vlen);
    end
  endtask

  task automatic put_quote(input int bl, input int vlen);
    put_header(16'(bl), quote_id);
    put_rand(bl);
    put_varstr(vlen);
  endtask

  task automatic put_trade(input int bl, input int el, input logic [31:0] n, input int vlen);
    put_header(16'(bl), trade_id);
    put_rand(bl);
    put_le(16'(el), 2);
    put_le(n, 4);
    for (int i = 0; i < int'(n); i++) put_rand(el);
    put_varstr(vlen);
  endtask

  function automatic logic [15:0] other_id();
    logic [15:0] id;
    do id = 16'($urandom); while (id == quote_id || id == trade_id);
    return id;
  endfunction

  task automatic put_unknown(input int bl, input int vlen);
    put_header(16'(bl), other_id());
    put_rand(bl);
    put_varstr(vlen);
  endtask

  task automatic test_directed();
    put_quote(50, 3); send_frame();
    put_trade(18, 27, 2, 0); send_frame();
    put_unknown(4, 2); send_frame();
    put_unknown(0, 0); put_quote(55, -1); send_frame();
    // Short quote block: malformed, and the bytes after it are dropped.
    put_quote(49, 2); put_rand(7); send_frame();
    put_trade(17, 25, 1, 0); send_frame();
    // Entry shorter than the trade fields.
    put_trade(18, 24, 1, 0); send_frame();
    // An empty group may carry any entry length.
    put_trade(20, 5, 0, 1); send_frame();
    // Frames that stop inside a header, a block and a var string.
    put_rand(3); send_frame();
    frame_bytes.push_back(8'h00); send_frame();
    put_quote(50, -1); void'(frame_bytes.pop_back()); send_frame();
    put_unknown(2, 6); void'(frame_bytes.pop_back()); send_frame();
    // A frame that stops where a var string length is due is clean.
    put_trade(18, 25, 1, -1); send_frame();
    // Huge entry count cut off after one entry.
    put_trade(18, 25, 32'hFFFF_FFFF, -1);
    put_rand(25); send_frame();
    // The last byte of the frame carries a trade record: no truncation report.
    put_trade(18, 25, 1, -1); put_trade(18, 25, 2, -1);
    repeat (25) void'(frame_bytes.pop_back()); send_frame();
    // Extreme field contents.
    put_header(16'd50, quote_id);
    repeat (50) frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'hFF); repeat (255) frame_bytes.push_back(8'h00);
    send_frame();
    // Longest entry length, cut off a little after its trade fields.
    put_header(16'd18, trade_id); repeat (18) frame_bytes.push_back(8'h00);
    put_le(16'hFFFF, 2); put_le(32'd1, 4); repeat (40) frame_bytes.push_back(8'h80);
    send_frame();
    wait_idle();
  endtask

  task automatic test_config();
    write_reg(sbe_pkg::REG_QUOTE, 16'h0000);
    write_reg(sbe_pkg::REG_TRADE, 16'hFFFF);
    put_quote(52, 1); put_trade(19, 26, 2, 0);
    put_header(16'd3, sbe_pkg::TRADE_RESET); put_rand(3); frame_bytes.push_back(8'h00);
    send_frame();
    wait_idle();
    // Equal templates: the quote layout takes precedence.
    write_reg(sbe_pkg::REG_QUOTE, 16'h1234);
    write_reg(sbe_pkg::REG_TRADE, 16'h1234);
    put_quote(50, 0); put_header(16'd20, 16'h1234); put_rand(20); send_frame();
    wait_idle();
    write_reg(sbe_pkg::REG_QUOTE, sbe_pkg::QUOTE_RESET);
    write_reg(sbe_pkg::REG_TRADE, sbe_pkg::TRADE_RESET);
    put_quote(50, 0); put_trade(18, 25, 1, 0); send_frame();
    wait_idle();
  endtask

  // One random frame: mostly well-formed messages, some broken or noise.
  task automatic put_random_frame();
    int pick, msgs, cut;
    pick = $urandom_range(99);
    if (pick < 6) begin
      put_rand($urandom_range(20, 1));
      return;
    end
    msgs = $urandom_range(3, 1);
    for (int m = 0; m < msgs; m++) begin
      int vlen;
      vlen = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(3);
      if (m == msgs - 1 && $urandom_range(3) == 0) vlen = -1;
      case ($urandom_range(9))
        0, 1, 2, 3: put_quote(($urandom_range(19) == 0) ? $urandom_range(49, 40)
                                                        : $urandom_range(58, 50), vlen);
        4, 5, 6, 7: put_trade(($urandom_range(19) == 0) ? $urandom_range(17, 8)
                                                        : $urandom_range(22, 18),
                              ($urandom_range(14) == 0) ? $urandom_range(24, 10)
                                                        : $urandom_range(30, 25),
                              $urandom_range(3), vlen);
        default: put_unknown($urandom_range(12), vlen);
      endcase
    end
    if (pick < 20) begin
      cut = $urandom_range(frame_bytes.size() - 1, 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
  endtask

  task automatic test_random(input int byte_budget);
    int sent;
    sent = 0;
    while (sent < byte_budget) begin
      put_random_frame();
      sent += frame_bytes.size();
      send_frame();
    end
    wait_idle();
  endtask

  initial begin
    parser_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle = 22; snk_idle = 49;
    test_directed();
    src_idle = 49; snk_idle = 22;
    test_config();
    write_reg(sbe_pkg::REG_QUOTE, 16'($urandom));
    write_reg(sbe_pkg::REG_TRADE, 16'($urandom));
    test_random(100);
    write_reg(sbe_pkg::REG_QUOTE, sbe_pkg::QUOTE_RESET);
    write_reg(sbe_pkg::REG_TRADE, sbe_pkg::TRADE_RESET);
    src_idle = 0; snk_idle = 0;
    test_random(150);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_records.size() == 0) begin
      $display("sbe_market_data_decoder_tb OK");
    end else begin
      $display("sbe_market_data_decoder_tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/sbe_pkg.sv
src/sbe_market_data_decoder.sv
tb/sbe_market_data_decoder_tb.sv
